[src/madr_pkg.sv]
// Package for the multiply/accumulate/divide register unit.
// Holds command codes, CSR indices, the window size, timing constants and the channel structs.
// No dependencies.
package madr_pkg;

   localparam logic [3:0] CMD_WRBYTE = 4'd0;
   localparam logic [3:0] CMD_WRWORD = 4'd1;
   localparam logic [3:0] CMD_RDBYTE = 4'd2;
   localparam logic [3:0] CMD_MUL    = 4'd3;
   localparam logic [3:0] CMD_DIV    = 4'd4;
   localparam logic [3:0] CMD_SADJ_A = 4'd5;
   localparam logic [3:0] CMD_SADJ_C = 4'd6;
   localparam logic [3:0] CMD_CARRY  = 4'd7;
   localparam logic [3:0] CMD_UNSAFE = 4'd8;

   localparam logic [0:0] CSR_SIGNED = 1'd0;
   localparam logic [0:0] CSR_ACCUM  = 1'd1;

   localparam int WinSize = 32;

   localparam logic [63:0] MUL_TIME_LONG  = 64'd54;
   localparam logic [63:0] MUL_TIME_SHORT = 64'd44;
   localparam logic [63:0] DIV_TIME_BASE  = 64'd176;
   localparam logic [8:0]  DIV_TIME_STEP  = 9'd14;

   // Input payload: cmd, tick, reg_offset, write_data (89 bits, padded to 96).
   typedef struct packed {
      logic [15:0] write_data;
      logic [4:0]  reg_offset;
      logic [63:0] tick;
      logic [3:0]  cmd;
   } req_type;

   // Result payload: read_data, busy_res, warning, carry_flag, unsafe_flag.
   typedef struct packed {
      logic unsafe_flag;
      logic carry_flag;
      logic warning;
      logic busy_res;
      logic [7:0] read_data;
   } rsp_type;

endpackage

[src/mul_acc_div_register_unit.sv]
// Top level of the multiply/accumulate/divide register unit.
// Access, flag and sign-adjust commands and a divide by zero go from the execute state
// to the response; multiply adds a product state (and an accumulate state in accumulate
// mode), divide a state of restoring steps (one restoring step per cycle in a shared
// 18-bit subtractor). One transaction in flight; a new request is taken only when idle,
// after the response has left. Synchronous active-high reset: window bytes to 0xFF,
// flags, signs and deadline to zero, modes off. Depends on madr_pkg.
module mul_acc_div_register_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[3:0], tick[67:4], reg_offset[72:68], write_data[88:73], zeros above
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], busy_res[8], warning[9], carry_flag[10], unsafe_flag[11]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_RSP  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  win_ff [madr_pkg::WinSize];
   logic [63:0] finish_ff, finish_in;
   logic [1:0]  sign_a_ff, sign_a_in, sign_c_ff, sign_c_in;
   logic        warn_ff, warn_in, carry_ff, carry_in, unsafe_ff, unsafe_in;
   logic        smode_ff, amode_ff;
   madr_pkg::req_type req_ff;
   madr_pkg::rsp_type rsp_ff, rsp_in;
   logic        busy_ff, busy_in;
   // shared datapath registers: product / dividend-quotient and remainder
   logic [31:0] acc_ff, acc_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [15:0] ab, cd, np, sadj_v, sadj_neg;
   logic [31:0] efgh, jklm, prod_fix, acc_sum;
   logic [17:0] trial;
   logic [4:0]  lz;
   logic        sadj_is_neg;
   logic        wr_en;
   logic [4:0]  wr_ofs;
   logic [7:0]  wr_byte;
   logic        wr2_en;
   logic [4:0]  wr2_ofs;
   logic [7:0]  wr2_byte;
   logic        w32_en;
   logic [4:0]  w32_ofs;
   logic [31:0] w32_val;
   logic        w32b_en;
   logic [31:0] w32b_val;

   assign ab   = {win_ff[5], win_ff[4]};
   assign cd   = {win_ff[3], win_ff[2]};
   assign np   = {win_ff[7], win_ff[6]};
   assign efgh = {win_ff[19], win_ff[18], win_ff[17], win_ff[16]};
   assign jklm = {win_ff[31], win_ff[30], win_ff[29], win_ff[28]};

   // Count leading zeros of the divisor
   always_comb begin
      lz = 5'd16;
      for (int i = 0; i < 16; i++) begin
         if (np[i]) lz = 5'(15 - i);
      end
   end

   assign sadj_v      = (req_ff.cmd == madr_pkg::CMD_SADJ_A) ? ab : cd;
   assign sadj_is_neg = ((sadj_v - 16'd1) & 16'h8000) != 16'd0;
   assign sadj_neg    = (sadj_v ^ 16'hFFFF) + 16'd1;
   assign prod_fix    = (smode_ff && (sign_a_ff + sign_c_ff) == 2'd0) ?
                        (acc_ff ^ 32'hFFFF_FFFF) + 32'd1 : acc_ff;
   assign acc_sum     = jklm + acc_ff;
   assign trial       = {rem_ff, acc_ff[31]} - {2'b00, np};

   // Sequencer and shared datapath
   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      sign_a_in = sign_a_ff;
      sign_c_in = sign_c_ff;
      warn_in   = warn_ff;
      carry_in  = carry_ff;
      unsafe_in = unsafe_ff;
      rsp_in    = rsp_ff;
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      wr_en = 1'b0; wr_ofs = req_ff.reg_offset; wr_byte = req_ff.write_data[7:0];
      wr2_en = 1'b0; wr2_ofs = {req_ff.reg_offset[4:1], 1'b1};
      wr2_byte = req_ff.write_data[15:8];
      w32_en = 1'b0; w32_ofs = 5'd16; w32_val = acc_ff;
      w32b_en = 1'b0; w32b_val = 32'd0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            busy_in = req_ff.tick < finish_ff;
            rsp_in.read_data = 8'd0;
            state_in = ST_RSP;
            case (req_ff.cmd)
               madr_pkg::CMD_WRBYTE: begin
                  if (busy_in) unsafe_in = 1'b1;
                  wr_en = 1'b1;
               end
               madr_pkg::CMD_WRWORD: begin
                  if (busy_in) unsafe_in = 1'b1;
                  wr_en = 1'b1; wr_ofs = {req_ff.reg_offset[4:1], 1'b0};
                  wr2_en = 1'b1;
               end
               madr_pkg::CMD_RDBYTE: begin
                  if (busy_in) unsafe_in = 1'b1;
                  rsp_in.read_data = win_ff[req_ff.reg_offset];
               end
               madr_pkg::CMD_MUL: begin
                  finish_in = req_ff.tick + ((smode_ff || amode_ff) ?
                              madr_pkg::MUL_TIME_LONG : madr_pkg::MUL_TIME_SHORT);
                  warn_in = 1'b0;
                  acc_in = ab * cd;
                  state_in = ST_MUL;
               end
               madr_pkg::CMD_DIV: begin
                  finish_in = req_ff.tick + madr_pkg::DIV_TIME_BASE
                            + 64'(madr_pkg::DIV_TIME_STEP * 9'(lz));
                  warn_in = 1'b0;
                  if (np == 16'd0) begin
                     warn_in = 1'b1; carry_in = 1'b1;
                     w32_en = 1'b1; w32_ofs = 5'd2; w32_val = 32'hFFFF_FFFF;
                     w32b_en = 1'b1;
                  end else begin
                     acc_in = efgh; rem_in = 17'd0; cnt_in = 6'd0;
                     state_in = ST_DIV;
                  end
               end
               madr_pkg::CMD_SADJ_A, madr_pkg::CMD_SADJ_C: begin
                  if (smode_ff) begin
                     wr_en = 1'b1; wr2_en = 1'b1;
                     wr_ofs  = (req_ff.cmd == madr_pkg::CMD_SADJ_A) ? 5'd4 : 5'd2;
                     wr2_ofs = wr_ofs + 5'd1;
                     {wr2_byte, wr_byte} = sadj_is_neg ? sadj_neg : sadj_v;
                     if (req_ff.cmd == madr_pkg::CMD_SADJ_A)
                        sign_a_in = sadj_is_neg ? 2'b11 : 2'b01;
                     else
                        sign_c_in = sadj_is_neg ? 2'b11 : 2'b01;
                  end
               end
               madr_pkg::CMD_CARRY:  carry_in  = req_ff.write_data[0];
               madr_pkg::CMD_UNSAFE: unsafe_in = req_ff.write_data[0];
               default: ;
            endcase
         end
         ST_MUL: begin
            acc_in = prod_fix;
            w32_en = 1'b1; w32_val = prod_fix;
            state_in = amode_ff ? ST_ACC : ST_RSP;
         end
         ST_ACC: begin
            carry_in = acc_sum[31] != jklm[31];
            warn_in  = carry_in;
            w32b_en = 1'b1; w32b_val = acc_sum;
            state_in = ST_RSP;
         end
         ST_DIV: begin
            // one restoring step: shift in the next dividend bit
            if (!trial[17]) rem_in = trial[16:0];
            else rem_in = {rem_ff[15:0], acc_ff[31]};
            acc_in = {acc_ff[30:0], ~trial[17]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               w32_en = 1'b1; w32_ofs = 5'd2; w32_val = acc_in;
               w32b_en = 1'b1; w32b_val = {16'd0, rem_in[15:0]};
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            rsp_in.busy_res = busy_ff;
            rsp_in.warning = warn_ff;
            rsp_in.carry_flag = carry_ff;
            rsp_in.unsafe_flag = unsafe_ff;
            if (rsp_tvalid && rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Window storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < madr_pkg::WinSize; i++) win_ff[i] <= 8'hFF;
      end else begin
         if (wr_en)  win_ff[wr_ofs]  <= wr_byte;
         if (wr2_en) win_ff[wr2_ofs] <= wr2_byte;
         if (w32_en) begin
            win_ff[w32_ofs]        <= w32_val[7:0];
            win_ff[w32_ofs + 5'd1] <= w32_val[15:8];
            win_ff[w32_ofs + 5'd2] <= w32_val[23:16];
            win_ff[w32_ofs + 5'd3] <= w32_val[31:24];
         end
         if (w32b_en) begin
            win_ff[28] <= w32b_val[7:0];
            win_ff[29] <= w32b_val[15:8];
            win_ff[30] <= w32b_val[23:16];
            win_ff[31] <= w32b_val[31:24];
         end
      end
   end

   // Control state, flags and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; finish_ff <= 64'd0;
         sign_a_ff <= 2'd0; sign_c_ff <= 2'd0;
         warn_ff <= 1'b0; carry_ff <= 1'b0; unsafe_ff <= 1'b0;
         smode_ff <= 1'b0; amode_ff <= 1'b0;
         busy_ff <= 1'b0; cnt_ff <= 6'd0;
      end else begin
         state_ff <= state_in; finish_ff <= finish_in;
         sign_a_ff <= sign_a_in; sign_c_ff <= sign_c_in;
         warn_ff <= warn_in; carry_ff <= carry_in; unsafe_ff <= unsafe_in;
         busy_ff <= busy_in; cnt_ff <= cnt_in;
         if (csr_we && csr_index == madr_pkg::CSR_SIGNED) smode_ff <= csr_wdata[0];
         if (csr_we && csr_index == madr_pkg::CSR_ACCUM)  amode_ff <= csr_wdata[0];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) req_ff <= req_tdata[88:0];
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RSP);
   assign rsp_tdata  = {4'd0, rsp_in};

   // Response carries current flags
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10] == carry_ff && rsp_tdata[11] == unsafe_ff)
      else $error("response flags differ from state");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < 6'd32)
      else $error("divide step counter overran");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_EXEC)
      else $error("accepted request not executed");
   a_signs: assert property (@(posedge clock) disable iff (reset)
      sign_a_ff != 2'b10 && sign_c_ff != 2'b10)
      else $error("invalid sign code");

endmodule

[bench/tb.sv]
// Testbench for mul_acc_div_register_unit: drives request transactions, predicts
// each response from a behavioral copy of the register window, and compares.
// Depends on madr_pkg and the unit's RTL.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [0:0]  csr_wdata = '0;

   mul_acc_div_register_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted unit state
   logic [7:0]  win [madr_pkg::WinSize];
   logic [63:0] deadline;
   int          sgn_a, sgn_c;
   logic        warn_q, carry_q, unsafe_q, mode_signed, mode_accum;
   madr_pkg::rsp_type pending_rsp [$];
   int          errors = 0;
   int          hold_off = 0;
   int          long_gap = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic logic [15:0] rd16(input int o);
      return {win[o+1], win[o]};
   endfunction

   function automatic void wr16(input int o, input logic [15:0] v);
      win[o] = v[7:0];
      win[o+1] = v[15:8];
   endfunction

   function automatic void wr32(input int o, input logic [31:0] v);
      wr16(o, v[15:0]);
      wr16(o + 2, v[31:16]);
   endfunction

   // sign adjust of the pair at offset o, returns the new sign
   function automatic int sign_fix(input int o);
      logic [15:0] v, vm1;
      v = rd16(o);
      vm1 = v - 16'd1;
      if (vm1[15]) begin
         wr16(o, -v);
         return -1;
      end
      return 1;
   endfunction

   function automatic madr_pkg::rsp_type predict_rsp(input madr_pkg::req_type r);
      madr_pkg::rsp_type p;
      logic [31:0] prod, prev, acc, num;
      logic [15:0] np;
      int          lz;
      logic        busy;
      busy = r.tick < deadline;
      p = '0;
      case (r.cmd)
         madr_pkg::CMD_WRBYTE: begin
            if (busy) unsafe_q = 1'b1;
            win[r.reg_offset] = r.write_data[7:0];
         end
         madr_pkg::CMD_WRWORD: begin
            if (busy) unsafe_q = 1'b1;
            wr16({r.reg_offset[4:1], 1'b0}, r.write_data);
         end
         madr_pkg::CMD_RDBYTE: begin
            if (busy) unsafe_q = 1'b1;
            p.read_data = win[r.reg_offset];
         end
         madr_pkg::CMD_MUL: begin
            deadline = r.tick + ((mode_signed || mode_accum) ?
                       madr_pkg::MUL_TIME_LONG : madr_pkg::MUL_TIME_SHORT);
            warn_q = 1'b0;
            prod = rd16(4) * rd16(2);
            if (mode_signed && sgn_a + sgn_c == 0) prod = -prod;
            wr32(16, prod);
            if (mode_accum) begin
               prev = {rd16(30), rd16(28)};
               acc = prev + prod;
               carry_q = acc[31] != prev[31];
               warn_q = carry_q;
               wr32(28, acc);
            end
         end
         madr_pkg::CMD_DIV: begin
            np = rd16(6);
            lz = 16;
            for (int b = 15; b >= 0; b--) if (np[b]) begin lz = 15 - b; break; end
            deadline = r.tick + madr_pkg::DIV_TIME_BASE + 64'(14 * lz);
            warn_q = 1'b0;
            if (np != 0) begin
               num = {rd16(18), rd16(16)};
               wr32(2, num / np);
               wr32(28, num % np);
            end else begin
               wr32(2, 32'hFFFF_FFFF);
               wr32(28, 32'h0);
               warn_q = 1'b1;
               carry_q = 1'b1;
            end
         end
         madr_pkg::CMD_SADJ_A: if (mode_signed) sgn_a = sign_fix(4);
         madr_pkg::CMD_SADJ_C: if (mode_signed) sgn_c = sign_fix(2);
         madr_pkg::CMD_CARRY:  carry_q = r.write_data[0];
         madr_pkg::CMD_UNSAFE: unsafe_q = r.write_data[0];
         default: ;
      endcase
      p.busy_res = busy;
      p.warning = warn_q;
      p.carry_flag = carry_q;
      p.unsafe_flag = unsafe_q;
      return p;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request transaction and queue its predicted response
   task automatic send_req(input logic [3:0] cmd, input logic [63:0] tick,
                           input logic [4:0] ofs, input logic [15:0] wd);
      madr_pkg::req_type r;
      int      g;
      r.cmd = cmd; r.tick = tick; r.reg_offset = ofs; r.write_data = wd;
      g = (long_gap > 0) ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, r};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(predict_rsp(r));
   endtask

   // stop offering and wait for every expected response
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic v);
      drain();
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == madr_pkg::CSR_SIGNED) mode_signed = v; else mode_accum = v;
   endtask

   // receiver with random stalls and one long hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            madr_pkg::rsp_type got, want;
            got = rsp_tdata[11:0];
            if (rsp_tdata[15:12] != 0) report("pad", rsp_tdata[15:12], 0);
            if (pending_rsp.size() == 0) begin
               report("unexpected", rsp_tdata, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
               if (got.busy_res != want.busy_res) report("busy_res", got.busy_res, want.busy_res);
               if (got.warning != want.warning) report("warning", got.warning, want.warning);
               if (got.carry_flag != want.carry_flag) report("carry_flag", got.carry_flag, want.carry_flag);
               if (got.unsafe_flag != want.unsafe_flag) report("unsafe_flag", got.unsafe_flag, want.unsafe_flag);
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 2 ? 1'b0 : 1'b0);
         end
      end
   end

   logic [63:0] now_tick = 64'd1000;

   function automatic logic [4:0] pick_ofs();
      logic [4:0] set [8] = '{5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd16, 5'd28};
      if ($urandom_range(0, 2) == 0) return 5'($urandom_range(0, 31));
      return set[$urandom_range(0, 7)] + 5'($urandom_range(0, 1) * 0);
   endfunction

   task automatic test_directed();
      send_req(madr_pkg::CMD_RDBYTE, 64'd0, 5'd0, 16'h0);
      send_req(madr_pkg::CMD_RDBYTE, 64'd0, 5'd31, 16'h0);
      send_req(madr_pkg::CMD_WRWORD, 64'd5, 5'd5, 16'hFFFF);        // odd word offset
      send_req(madr_pkg::CMD_WRWORD, 64'd5, 5'd2, 16'h8000);
      send_req(madr_pkg::CMD_MUL, 64'hFFFF_FFFF_FFFF_FFF0, 5'd0, 16'h0); // deadline wraps
      send_req(madr_pkg::CMD_RDBYTE, 64'd2, 5'd19, 16'h0);
      send_req(madr_pkg::CMD_WRWORD, 64'd100, 5'd6, 16'h0);
      send_req(madr_pkg::CMD_DIV, 64'd100, 5'd0, 16'h0);            // divide by zero
      send_req(madr_pkg::CMD_WRBYTE, 64'd120, 5'd3, 16'hABCD);      // unsafe write
      send_req(madr_pkg::CMD_UNSAFE, 64'd200, 5'd0, 16'h0);
      send_req(madr_pkg::CMD_CARRY, 64'd200, 5'd0, 16'hFFFE);
      send_req(madr_pkg::CMD_CARRY, 64'd200, 5'd0, 16'h0001);
      send_req(madr_pkg::CMD_UNSAFE, 64'd200, 5'd0, 16'h0001);
      send_req(madr_pkg::CMD_SADJ_A, 64'd300, 5'd0, 16'h0);         // no effect unsigned
      send_req(madr_pkg::CMD_WRWORD, 64'd1000, 5'd6, 16'h0001);
      send_req(madr_pkg::CMD_DIV, 64'd1000, 5'd0, 16'h0);
      send_req(4'd9, 64'd2000, 5'd0, 16'h0);
      send_req(4'd15, 64'd2000, 5'd31, 16'hFFFF);
      send_req(madr_pkg::CMD_RDBYTE, 64'd2000, 5'd2, 16'h0);
      send_req(madr_pkg::CMD_RDBYTE, 64'd2000, 5'd28, 16'h0);
   endtask

   task automatic test_signed_ops();
      write_csr(madr_pkg::CSR_SIGNED, 1'b1);
      send_req(madr_pkg::CMD_MUL, 64'd3000, 5'd0, 16'h0);           // signs both zero
      send_req(madr_pkg::CMD_WRWORD, 64'd3100, 5'd4, 16'h0000);
      send_req(madr_pkg::CMD_SADJ_A, 64'd3100, 5'd0, 16'h0);        // zero is negative
      send_req(madr_pkg::CMD_WRWORD, 64'd3100, 5'd2, 16'h8000);
      send_req(madr_pkg::CMD_SADJ_C, 64'd3100, 5'd0, 16'h0);        // 0x8000 is positive
      send_req(madr_pkg::CMD_MUL, 64'd3100, 5'd0, 16'h0);
      write_csr(madr_pkg::CSR_ACCUM, 1'b1);
      send_req(madr_pkg::CMD_MUL, 64'd4000, 5'd0, 16'h0);
      send_req(madr_pkg::CMD_MUL, 64'd4000, 5'd0, 16'h0);
   endtask

   task automatic run_random(input int count);
      logic [3:0]  cmd;
      logic [15:0] wd;
      int          k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         if (k < 25) cmd = madr_pkg::CMD_WRWORD;
         else if (k < 35) cmd = madr_pkg::CMD_WRBYTE;
         else if (k < 50) cmd = madr_pkg::CMD_RDBYTE;
         else if (k < 65) cmd = madr_pkg::CMD_MUL;
         else if (k < 75) cmd = madr_pkg::CMD_DIV;
         else if (k < 83) cmd = madr_pkg::CMD_SADJ_A;
         else if (k < 91) cmd = madr_pkg::CMD_SADJ_C;
         else if (k < 94) cmd = madr_pkg::CMD_CARRY;
         else if (k < 97) cmd = madr_pkg::CMD_UNSAFE;
         else cmd = 4'($urandom_range(9, 15));
         k = $urandom_range(0, 9);
         wd = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : (k == 2) ? 16'h8000 :
              (k == 3) ? 16'h0001 : 16'($urandom);
         now_tick = now_tick + 64'($urandom_range(0, 120));
         if ($urandom_range(0, 49) == 0) now_tick = {$urandom, $urandom};
         send_req(cmd, now_tick, pick_ofs(), wd);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      long_gap = 1;
      run_random(12);
      long_gap = 0;
      drain();
   endtask

   initial begin
      foreach (win[i]) win[i] = 8'hFF;
      deadline = '0; sgn_a = 0; sgn_c = 0;
      warn_q = 0; carry_q = 0; unsafe_q = 0; mode_signed = 0; mode_accum = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_signed_ops();
      test_backpressure();
      write_csr(madr_pkg::CSR_SIGNED, 1'b0); write_csr(madr_pkg::CSR_ACCUM, 1'b0);
      run_random(180);
      write_csr(madr_pkg::CSR_ACCUM, 1'b1);
      run_random(180);
      write_csr(madr_pkg::CSR_SIGNED, 1'b1);
      run_random(200);
      write_csr(madr_pkg::CSR_ACCUM, 1'b0);
      run_random(180);
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
